### hw/rtl/sha_pkg.sv
`timescale 1ns / 1ps
package sha_pkg;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned Rounds = 64;

  typedef logic [31:0] word_t;

  typedef enum logic [0:0] {
    CMD_ABSORB = 1'b0,
    CMD_FINISH = 1'b1
  } cmd_t;

  // Queue entry between the byte front end and the compression engine.
  typedef struct packed {
    cmd_t       command;
    logic [7:0] data_byte;
  } req_t;

  function automatic word_t round_k(input logic [5:0] t);
    word_t k;
    begin
      unique case (t)
        6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
        6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
        6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
        6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
        6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
        6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
        6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
        6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
        6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
        6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
        6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
        6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
        6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
        6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
        6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
        6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
        6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
        6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
        6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
        6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
        6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
        6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
        6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
        6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
        6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
        6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
        6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
        6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
        6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
        6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
        6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
        6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
      endcase
      return k;
    end
  endfunction

  function automatic word_t init_hash(input logic [2:0] i);
    word_t h;
    begin
      unique case (i)
        3'd0: h = 32'h6a09e667;
        3'd1: h = 32'hbb67ae85;
        3'd2: h = 32'h3c6ef372;
        3'd3: h = 32'ha54ff53a;
        3'd4: h = 32'h510e527f;
        3'd5: h = 32'h9b05688c;
        3'd6: h = 32'h1f83d9ab;
        default: h = 32'h5be0cd19;
      endcase
      return h;
    end
  endfunction

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

### hw/rtl/sha_queue.sv
`timescale 1ns / 1ps
module sha_queue
  import sha_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_req,
  output logic out_valid,
  input  logic out_ready,
  output req_t out_req
);

  // two-entry queue
  req_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_req   = slot[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= in_req;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue overflow");
  assert property (@(posedge clk) disable iff (rst) (count == 2'd0) |-> !pop)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 2'd1))
    else $error("count lost a push");

endmodule

### hw/rtl/sha_engine.sv
`timescale 1ns / 1ps
module sha_engine
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  req_t        req,
  output logic        digest_valid,
  input  logic        digest_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_PAD   = 5'b00010,
    S_ROUND = 5'b00100,
    S_FOLD  = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t      state;
  word_t       h [8];
  word_t       v [8];
  word_t       w [16];
  logic [5:0]  fill;
  logic [63:0] msg_bits;
  logic [5:0]  rnd;
  logic        final_blk;
  logic        pad_second;
  logic [2:0]  out_idx;

  word_t t1, t2, s0, s1, w_new, ew, aw;
  logic [1:0] bsel;
  logic [3:0] wsel;

  assign req_ready    = (state == S_IDLE);
  assign digest_valid = (state == S_EMIT);
  assign digest_word  = h[out_idx];
  assign word_index   = out_idx;
  assign last_word    = (out_idx == 3'd7);
  assign wsel         = fill[5:2];
  assign bsel         = fill[1:0];

  always_comb begin
    ew = v[4];
    aw = v[0];
    t1 = v[7] + (rotr(ew, 6) ^ rotr(ew, 11) ^ rotr(ew, 25)) +
         ((ew & v[5]) ^ (~ew & v[6])) + round_k(rnd) + w[0];
    t2 = (rotr(aw, 2) ^ rotr(aw, 13) ^ rotr(aw, 22)) +
         ((aw & v[1]) ^ (aw & v[2]) ^ (v[1] & v[2]));
    s0 = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
    s1 = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
    w_new = w[0] + s0 + w[9] + s1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill <= '0;
      msg_bits <= '0;
      out_idx <= '0;
      final_blk <= 1'b0;
      pad_second <= 1'b0;
      rnd <= '0;
      for (int i = 0; i < 8; i++) h[i] <= init_hash(3'(i));
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            if (req.command == CMD_ABSORB) begin
              w[wsel][8*(3-bsel) +: 8] <= req.data_byte;
              msg_bits <= msg_bits + 64'd8;
              fill <= fill + 6'd1;
              if (fill == 6'd63) begin
                state <= S_ROUND;
                final_blk <= 1'b0;
                rnd <= '0;
                for (int i = 0; i < 8; i++) v[i] <= h[i];
              end
            end else begin
              // pad byte, zero the rest of this word
              w[wsel] <= (w[wsel] & ~(32'hffffffff >> (8 * bsel))) |
                         (32'h80000000 >> (8 * bsel));
              fill <= {wsel + 4'd1, 2'b00};
              pad_second <= (fill >= 6'd56);
              if (wsel == 4'd15) begin
                // pad byte fills the block: compress it straight away
                final_blk <= 1'b0;
                state <= S_ROUND;
                rnd <= '0;
                for (int i = 0; i < 8; i++) v[i] <= h[i];
              end else begin
                state <= S_PAD;
              end
            end
          end
        end
        S_PAD: begin
          // one zero word a cycle, then the two length words at once
          if (fill[5:2] == 4'd14 && !pad_second) begin
            w[14] <= msg_bits[63:32];
            w[15] <= msg_bits[31:0];
            final_blk <= 1'b1;
            state <= S_ROUND;
            rnd <= '0;
            for (int i = 0; i < 8; i++) v[i] <= h[i];
          end else begin
            w[wsel] <= '0;
            fill <= fill + 6'd4;
            if (wsel == 4'd15) begin
              final_blk <= 1'b0;
              state <= S_ROUND;
              rnd <= '0;
              for (int i = 0; i < 8; i++) v[i] <= h[i];
            end
          end
        end
        S_ROUND: begin
          for (int i = 0; i < 15; i++) w[i] <= w[i+1];
          w[15] <= w_new;
          v[0] <= t1 + t2;
          v[1] <= v[0];
          v[2] <= v[1];
          v[3] <= v[2];
          v[4] <= v[3] + t1;
          v[5] <= v[4];
          v[6] <= v[5];
          v[7] <= v[6];
          rnd <= rnd + 6'd1;
          if (rnd == 6'd63) begin
            state <= S_FOLD;
          end
        end
        S_FOLD: begin
          for (int i = 0; i < 8; i++) h[i] <= h[i] + v[i];
          if (final_blk) begin
            state <= S_EMIT;
            out_idx <= '0;
          end else if (pad_second) begin
            pad_second <= 1'b0;
            fill <= '0;
            state <= S_PAD;
          end else begin
            state <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (digest_ready) begin
            out_idx <= out_idx + 3'd1;
            if (out_idx == 3'd7) begin
              state <= S_IDLE;
              fill <= '0;
              msg_bits <= '0;
              for (int i = 0; i < 8; i++) h[i] <= init_hash(3'(i));
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND && rnd == 6'd63) |=> (state == S_FOLD))
    else $error("round count slipped");
  assert property (@(posedge clk) disable iff (rst)
    (digest_valid && digest_ready && last_word) |=> (fill == 6'd0 && msg_bits == 64'd0))
    else $error("not reinitialised after digest");
  assert property (@(posedge clk) disable iff (rst)
    (digest_valid && !digest_ready) |=> (digest_valid && $stable(out_idx)))
    else $error("digest word dropped");

endmodule

### hw/rtl/sha256_byte_stream_hasher.sv
`timescale 1ns / 1ps
// SHA-256 over a byte stream. Requests pass a two-entry queue to a
// compression engine that runs one round per cycle. An absorb stores its
// byte; every 64th byte starts the 64 rounds and the fold, during which the
// engine takes no request. A finish stores the pad byte, zero words and the
// length, runs one or two compressions, then offers the eight digest words
// one per cycle while out_ready is high, word 0 first, then starts afresh.
module sha256_byte_stream_hasher
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);

  req_t in_req;
  req_t q_req;
  logic q_valid;
  logic q_ready;

  assign in_req.command   = cmd_t'(command);
  assign in_req.data_byte = data_byte;

  sha_queue u_queue (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_req(in_req),
    .out_valid(q_valid), .out_ready(q_ready), .out_req(q_req)
  );

  sha_engine u_engine (
    .clk(clk), .rst(rst),
    .req_valid(q_valid), .req_ready(q_ready), .req(q_req),
    .digest_valid(out_valid), .digest_ready(out_ready),
    .digest_word(digest_word), .word_index(word_index), .last_word(last_word)
  );

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
module testbench
  import sha_pkg::*;
();

  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_exp_t;

  localparam int unsigned CycleLimit = 2000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        command = 1'b0;
  logic [7:0]  data_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  sha256_byte_stream_hasher dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .data_byte(data_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .digest_word(digest_word), .word_index(word_index), .last_word(last_word)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  logic [31:0] chain[8];
  logic [7:0]  blk[64];
  logic [5:0]  fill;
  logic [63:0] msg_bits;
  digest_exp_t digest_q[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatches = 0;
  int unsigned requests_sent = 0;
  int unsigned digests_seen = 0;
  longint unsigned cycles = 0;

  localparam logic [31:0] RoundK[64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
  localparam logic [31:0] InitChain[8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  function automatic logic [31:0] ror32(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic restart_hash();
    for (int i = 0; i < 8; i++) chain[i] = InitChain[i];
    fill = '0;
    msg_bits = '0;
  endtask

  task automatic fold_block();
    logic [31:0] w[64];
    logic [31:0] v[8];
    logic [31:0] t1, t2, s0, s1;
    for (int t = 0; t < 16; t++)
      w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
    for (int t = 16; t < 64; t++) begin
      s0 = ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3);
      s1 = ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10);
      w[t] = w[t-16] + s0 + w[t-7] + s1;
    end
    for (int i = 0; i < 8; i++) v[i] = chain[i];
    for (int t = 0; t < 64; t++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[t] + w[t];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      for (int i = 7; i > 0; i--) v[i] = v[i-1];
      v[4] = v[4] + t1;
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] += v[i];
  endtask

  task automatic predict_hash(cmd_t cmd, logic [7:0] b);
    int i;
    digest_exp_t e;
    if (cmd == CMD_ABSORB) begin
      blk[fill] = b;
      msg_bits += 64'd8;
      fill++;
      if (fill == 0) fold_block();
    end else begin
      i = fill;
      blk[i] = 8'h80;
      i = i + 1;
      if (i > 56) begin
        while (i < 64) begin
          blk[i] = 8'h00;
          i = i + 1;
        end
        fold_block();
        i = 0;
      end
      while (i < 56) begin
        blk[i] = 8'h00;
        i = i + 1;
      end
      for (int k = 0; k < 8; k++) blk[56+k] = msg_bits[63-8*k -: 8];
      fold_block();
      for (int k = 0; k < 8; k++) begin
        e.word = chain[k];
        e.index = 3'(k);
        e.last = (k == 7);
        digest_q.push_back(e);
      end
      restart_hash();
    end
  endtask

  task automatic send_request(cmd_t cmd, logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_valid = 1'b1;
    command = cmd;
    data_byte = b;
    predict_hash(cmd, b);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    requests_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic send_message(int n);
    for (int i = 0; i < n; i++) send_request(CMD_ABSORB, 8'($urandom));
    send_request(CMD_FINISH, 8'($urandom));
  endtask

  always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin
    digest_exp_t e;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
    if (!rst && out_valid && out_ready) begin
      digests_seen++;
      if (digest_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected digest word %h", digest_word);
      end else begin
        e = digest_q.pop_front();
        if (digest_word !== e.word || word_index !== e.index || last_word !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %h/%0d/%b got %h/%0d/%b", e.word, e.index, e.last,
                     digest_word, word_index, last_word);
        end
      end
    end
  end

  task automatic test_directed();
    send_request(CMD_FINISH, 8'hff);  // empty message
    send_message(0);
    send_message(1);
    send_request(CMD_ABSORB, 8'h00);
    send_request(CMD_ABSORB, 8'hff);
    send_request(CMD_ABSORB, 8'h55);
    send_request(CMD_ABSORB, 8'haa);
    send_request(CMD_FINISH, 8'h00);
    send_message(2);
  endtask

  task automatic test_padding_edges();
    // single-block/two-block padding boundary and exact block fill
    send_message(55);
    send_message(56);
    send_message(63);
    send_message(64);
  endtask

  task automatic test_random(int budget);
    int n;
    while (budget > 0) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(130) : $urandom_range(20);
      if (n > budget - 1) n = budget - 1;
      send_message(n);
      budget -= n + 1;
    end
  endtask

  task automatic drain();
    while (digest_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic run_phase(int unsigned s_pct, int unsigned r_pct, int budget);
    send_idle_pct = s_pct;
    recv_stall_pct = r_pct;
    test_random(budget);
  endtask

  initial begin
    restart_hash();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_padding_edges();
    run_phase(0, 0, 40);
    run_phase(61, 0, 40);
    run_phase(0, 61, 40);
    run_phase(29, 29, 46);
    drain();
    $display("sent %0d requests, checked %0d digest words over four pacing phases",
             requests_sent, digests_seen);
    if (mismatches == 0 && digest_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
